FILE: rtl/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg : shared types and constants of the prime sieve lister
// Field widths, the job word passed from front to engine, fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package psl_pkg;

   localparam int LIMIT_W     = 9;   // width of the limit field
   localparam int PRIME_W     = 8;   // width of a listed prime
   localparam int MIN_LIMIT   = 3;   // smallest limit that has a prime below it
   localparam int FIRST_PRIME = 2;   // first index that is sieved and scanned
   localparam int QUEUE_DEPTH = 2;   // jobs held between front and engine

   // one job as classified by the front
   typedef struct packed {
      logic [LIMIT_W-1:0] n;        // limit, already saturated
      logic               trivial;  // no prime below n
   } job_type;

endpackage : psl_pkg

`default_nettype wire

FILE: rtl/psl_front.sv
// ----------------------------------------------------------------------------
// psl_front : request intake
// Saturates the limit, flags limits without primes and queues the job.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_front
   import psl_pkg::*;
#(
   parameter int SIEVE_SIZE = 256
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire [LIMIT_W-1:0]  req_limit,
   output logic               job_valid,
   input  wire                job_ready,
   output job_type            job
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            ent_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic [LIMIT_W-1:0] n_sat;
   logic               push, pop;
   job_type            job_new;

   assign n_sat = (req_limit > LIMIT_W'(SIEVE_SIZE)) ? LIMIT_W'(SIEVE_SIZE) : req_limit;

   always_comb begin
      job_new.n       = n_sat;
      job_new.trivial = (n_sat < LIMIT_W'(MIN_LIMIT));
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign job_valid = (count_ff != '0);
   assign job       = ent_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = job_valid && job_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule : psl_front

`default_nettype wire

FILE: rtl/psl_engine.sv
// ----------------------------------------------------------------------------
// psl_engine : sieve engine
// Clears the mark store, marks multiples of each factor, scans and emits.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_engine
   import psl_pkg::*;
#(
   parameter int SIEVE_SIZE = 256
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                job_valid,
   output logic               job_ready,
   input  job_type            job,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [PRIME_W-1:0] rsp_prime_value,
   output logic               rsp_valid_res,
   output logic               rsp_last
);

   localparam int AW = $clog2(SIEVE_SIZE);
   localparam int CW = $clog2(SIEVE_SIZE + 1) + 1;  // headroom for i + f and f*f

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_CLEAR    = 8'b0000_0010,
      ST_FACTOR   = 8'b0000_0100,
      ST_MARK     = 8'b0000_1000,
      ST_SCAN_RD  = 8'b0001_0000,
      ST_SCAN_CHK = 8'b0010_0000,
      ST_FLUSH    = 8'b0100_0000,
      ST_EMPTY    = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      fac_ff, fac_in;
   logic [CW-1:0]      sq_ff, sq_in;
   logic [CW-1:0]      pend_ff, pend_in;
   logic [CW-1:0]      idx_inc;

   // mark store
   logic               marks [SIEVE_SIZE];
   logic               mark_we, mark_wd, mark_re;
   logic               mark_rd_ff;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic [PRIME_W-1:0] out_prime_ff, out_prime_in;
   logic               out_res_ff, out_res_in;
   logic               out_last_ff, out_last_in;
   logic               out_free, out_load;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign job_ready = (state_ff == ST_IDLE);
   assign idx_inc   = idx_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      fac_in       = fac_ff;
      sq_in        = sq_ff;
      pend_in      = pend_ff;
      mark_we      = 1'b0;
      mark_wd      = 1'b0;
      mark_re      = 1'b0;
      out_load     = 1'b0;
      out_prime_in = out_prime_ff;
      out_res_in   = out_res_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               n_in   = CW'(job.n);
               idx_in = '0;
               state_in = job.trivial ? ST_EMPTY : ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            mark_we = 1'b1;
            idx_in  = idx_inc;
            if (idx_inc >= n_ff) begin
               fac_in   = CW'(FIRST_PRIME);
               sq_in    = CW'(FIRST_PRIME * FIRST_PRIME);
               state_in = ST_FACTOR;
            end
         end
         ST_FACTOR: begin
            if (sq_ff > n_ff) begin
               idx_in   = CW'(FIRST_PRIME);
               state_in = ST_SCAN_RD;
            end else begin
               idx_in   = fac_ff << 1;
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (idx_ff < n_ff) begin
               mark_we = 1'b1;
               mark_wd = 1'b1;
               idx_in  = idx_ff + fac_ff;
            end else begin
               // (f+1)^2 = f^2 + 2f + 1
               fac_in   = fac_ff + 1'b1;
               sq_in    = sq_ff + (fac_ff << 1) + 1'b1;
               state_in = ST_FACTOR;
            end
         end
         ST_SCAN_RD: begin
            mark_re  = 1'b1;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            // a prime found here releases the held one, which is then not last
            if (!mark_rd_ff && idx_ff != CW'(FIRST_PRIME) && !out_free) begin
               state_in = ST_SCAN_CHK;
            end else begin
               if (!mark_rd_ff) begin
                  if (idx_ff != CW'(FIRST_PRIME)) begin
                     out_load     = 1'b1;
                     out_prime_in = PRIME_W'(pend_ff);
                     out_res_in   = 1'b1;
                     out_last_in  = 1'b0;
                  end
                  pend_in = idx_ff;
               end
               idx_in   = idx_inc;
               state_in = (idx_inc >= n_ff) ? ST_FLUSH : ST_SCAN_RD;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_prime_in = PRIME_W'(pend_ff);
               out_res_in   = 1'b1;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_prime_in = '0;
               out_res_in   = 1'b0;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      idx_ff  <= idx_in;
      fac_ff  <= fac_in;
      sq_ff   <= sq_in;
      pend_ff <= pend_in;
      if (out_load) begin
         out_prime_ff <= out_prime_in;
         out_res_ff   <= out_res_in;
         out_last_ff  <= out_last_in;
      end
   end

   // single port bit store, registered read
   always_ff @(posedge clock) begin
      if (mark_we) begin
         marks[idx_ff[AW-1:0]] <= mark_wd;
      end
      if (mark_re) begin
         mark_rd_ff <= marks[idx_ff[AW-1:0]];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_prime_value = out_prime_ff;
   assign rsp_valid_res   = out_res_ff;
   assign rsp_last        = out_last_ff;

endmodule : psl_engine

`default_nettype wire

FILE: rtl/prime_sieve_lister.sv
// Throughput: one transaction at a time in the engine; two more wait in the front queue.
// Limits below three give a single empty, final result.
// Reset: synchronous, active high; clears queue and engine control, marks are cleared
//   per transaction by a sweep over the first n entries, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
// prime_sieve_lister : sieve of Eratosthenes prime lister
// Lists, in ascending order, the primes below each requested limit.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_sieve_lister
   import psl_pkg::*;
#(
   parameter int SIEVE_SIZE = 256
) (
   input  wire                clock,
   input  wire                reset,
   // request channel: one limit per transaction
   input  wire                req_valid,
   output logic               req_ready,
   input  wire [LIMIT_W-1:0]  req_limit,
   // result channel: one prime or one empty result per transaction, last flags the final one
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [PRIME_W-1:0] rsp_prime_value,
   output logic               rsp_valid_res,
   output logic               rsp_last
);

   job_type job;
   logic    job_valid;
   logic    job_ready;

   // front: saturate limit, flag the no-prime case, queue the job
   psl_front #(
      .SIEVE_SIZE (SIEVE_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_limit (req_limit),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   // engine: clear, mark multiples, scan; one prime is held back so that
   // the last flag can be set once the scan reaches the limit
   psl_engine #(
      .SIEVE_SIZE (SIEVE_SIZE)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job_ready       (job_ready),
      .job             (job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_value (rsp_prime_value),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_last        (rsp_last)
   );

   // the no-prime result is always the only and final one
   a_empty_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> rsp_last)
      else $error("empty result without last");

   // a listed prime lies in the sieved range
   a_prime_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |->
         (rsp_prime_value >= PRIME_W'(FIRST_PRIME)) &&
         (int'(rsp_prime_value) < SIEVE_SIZE))
      else $error("prime out of range");

   // primes of one list rise strictly, checked across back-to-back accepted results
   a_ascending : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_valid_res && !rsp_last) ##1 (rsp_valid && rsp_ready)
         |-> (rsp_prime_value > $past(rsp_prime_value)))
      else $error("primes not ascending");

endmodule : prime_sieve_lister

`default_nettype wire

FILE: sim/prime_sieve_lister_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prime_sieve_lister_tb : self-checking bench for the prime sieve lister
// Drives limits through the request channel and rebuilds the prime list of
// each one with its own sieve. Every result transaction is checked in order.
// Both channels idle at random, apart from one long stretch without idling.
// ----------------------------------------------------------------------------

module prime_sieve_lister_tb;
   import psl_pkg::*;

   localparam int SIEVE_SIZE   = 256;
   localparam int MAX_LISTED   = 54;        // primes below 256, never exceeded
   localparam int RANDOM_ITEMS = 290;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int IDLE_PCT     = 11;
   localparam int DRAIN_CYCLES = 32;

   // one expected result transaction
   typedef struct packed {
      logic [PRIME_W-1:0] prime_value;
      logic               valid_res;
      logic               last;
   } listed_prime_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [LIMIT_W-1:0] req_limit = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [PRIME_W-1:0] rsp_prime_value;
   logic               rsp_valid_res;
   logic               rsp_last;

   logic [LIMIT_W-1:0] limit_q[$];      // limits still to be offered
   listed_prime_type   primes_due_q[$]; // primes owed by the block, oldest first

   int unsigned cycle_count    = 0;
   int unsigned limits_sent    = 0;
   int unsigned empty_lists    = 0;
   int unsigned clipped_limits = 0;
   int unsigned results_seen   = 0;
   int unsigned error_count    = 0;

   prime_sieve_lister #(
      .SIEVE_SIZE(SIEVE_SIZE)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_limit      (req_limit),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_prime_value(rsp_prime_value),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_last       (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sieve the limit and queue the primes the block should list for it.
   function automatic void sieve_limit(input logic [LIMIT_W-1:0] limit);
      bit               marks [SIEVE_SIZE];
      int unsigned      n;
      int unsigned      root;
      int unsigned      listed;
      listed_prime_type entry;
      n      = limit;
      root   = 0;
      listed = 0;
      if (n > SIEVE_SIZE) begin
         n = SIEVE_SIZE;
         clipped_limits++;
      end
      foreach (marks[i]) marks[i] = 1'b0;
      // below three there is nothing to list: a single empty, final result
      if (n < MIN_LIMIT) begin
         entry = '{prime_value: '0, valid_res: 1'b0, last: 1'b1};
         primes_due_q.push_back(entry);
         empty_lists++;
         return;
      end
      while ((root + 1) * (root + 1) <= n) root++;
      for (int unsigned f = FIRST_PRIME; f <= root; f++)
         for (int unsigned i = 2 * f; i < n; i += f)
            marks[i] = 1'b1;
      for (int unsigned i = FIRST_PRIME; i < n && listed < MAX_LISTED; i++) begin
         if (!marks[i]) begin
            entry = '{prime_value: i[PRIME_W-1:0], valid_res: 1'b1, last: 1'b0};
            primes_due_q.push_back(entry);
            listed++;
         end
      end
      // the final prime of the list carries the last flag
      entry      = primes_due_q.pop_back();
      entry.last = 1'b1;
      primes_due_q.push_back(entry);
   endfunction

   // Mostly short limits, which are cheap; a share of full and clipped sieves.
   function automatic logic [LIMIT_W-1:0] pick_limit();
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 50)
         return LIMIT_W'($urandom_range(0, 40));
      else if (kind < 75)
         return LIMIT_W'($urandom_range(0, SIEVE_SIZE));
      else if (kind < 88)
         return LIMIT_W'($urandom_range(SIEVE_SIZE + 1, (1 << LIMIT_W) - 1));
      else
         return LIMIT_W'($urandom_range(SIEVE_SIZE - 1, SIEVE_SIZE));
   endfunction

   // no idling on either side while this stretch of transactions goes through
   function automatic bit idle_roll();
      if (limits_sent >= 120 && limits_sent < 175)
         return 1'b0;
      return $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   // Request driver: holds valid and limit until the transaction is taken,
   // predicting the list at the edge of acceptance.
   always @(posedge clock) begin : request_driver
      bit taken;
      if (reset) begin
         req_valid <= 1'b0;
         req_limit <= '0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            sieve_limit(req_limit);
            limits_sent++;
         end
         if (!req_valid || taken) begin
            if (limit_q.size() != 0 && !idle_roll()) begin
               req_valid <= 1'b1;
               req_limit <= limit_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transaction against the oldest expected prime,
   // and stalls the channel at random.
   always @(posedge clock) begin : result_monitor
      listed_prime_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (primes_due_q.size() == 0) begin
               $display("%0t: result with nothing outstanding: prime %0d valid %0b last %0b",
                        $time, rsp_prime_value, rsp_valid_res, rsp_last);
               error_count++;
            end else begin
               due = primes_due_q.pop_front();
               if (rsp_prime_value !== due.prime_value) begin
                  $display("%0t: prime_value expected %0d, got %0d",
                           $time, due.prime_value, rsp_prime_value);
                  error_count++;
               end
               if (rsp_valid_res !== due.valid_res) begin
                  $display("%0t: valid_res expected %0b, got %0b",
                           $time, due.valid_res, rsp_valid_res);
                  error_count++;
               end
               if (rsp_last !== due.last) begin
                  $display("%0t: last expected %0b, got %0b (prime %0d)",
                           $time, due.last, rsp_last, due.prime_value);
                  error_count++;
               end
            end
         end
         rsp_ready <= !idle_roll();
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles, %0d primes still owed",
                  $time, cycle_count, primes_due_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic [LIMIT_W-1:0] directed [] = '{
         0, 1, 2,               // nothing to list
         3, 4, 5, 8,            // smallest lists, first square
         9, 10, 24, 25, 26,     // limits on and next to squares
         48, 49, 50, 120, 121, 168, 169, 170,
         255, 256,              // full sieve
         257, 300, 511          // clipped to the store size
      };
      foreach (directed[i]) limit_q.push_back(directed[i]);
      repeat (RANDOM_ITEMS) limit_q.push_back(pick_limit());

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // all limits taken, then all primes in, then a short quiet spell
      while (limit_q.size() != 0 || req_valid) @(negedge clock);
      while (primes_due_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sieved %0d limits (%0d with no prime, %0d clipped to %0d).",
               limits_sent, empty_lists, clipped_limits, SIEVE_SIZE);
      $display("Checked %0d result transactions in %0d cycles, %0d mismatches.",
               results_seen, cycle_count, error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
